FILE: rtl/bfva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfva_pkg
// Shared types and constants for the packed 16-bit float lane adder.
// ----------------------------------------------------------------------------
package bfva_pkg;
    localparam int unsigned LANE_W    = 16;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned MAX_LANES = WORD_W / LANE_W;

    localparam logic [0:0] REG_WIRE_FORMAT = 1'b0;
    localparam logic [0:0] REG_FLUSH_DENORM = 1'b1;

    localparam logic [31:0] DEFAULT_NAN32 = 32'hFFC0_0000;
    localparam logic [31:0] QUIET32       = 32'h0040_0000;
    localparam logic [31:0] BF_ROUND      = 32'h0000_8000;

    typedef struct packed {
        logic half_mode;
        logic ftz;
    } t_mode;

    // Stage 1 -> stage 2: aligned operands of one lane
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sub;
        logic        sign;
        logic [7:0]  exp;
        logic [27:0] big;
        logic [27:0] small_m;
    } t_al;

    // Stage 2 -> stage 3: raw sum of one lane
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [7:0]  exp;
        logic [28:0] mag;
    } t_sm;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] s;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [9:0]  nm;
        begin
            s   = {h[15], 31'd0};
            ex  = h[14:10];
            man = h[9:0];
            lz  = 4'd0;
            for (int i = 9; i >= 0; i--) begin
                if (man[i] && lz == 4'd0 && (man >> (i + 1)) == 10'd0)
                    lz = 4'(9 - i);
            end
            nm = 10'(man << (lz + 4'd1));
            if (ex == 5'h1F)
                half_to_single = s | 32'h7F80_0000 | {9'd0, man, 13'd0};
            else if (ex == 5'd0)
                half_to_single = (man == 10'd0) ? s :
                    s | {1'b0, 8'(8'd112 - {4'd0, lz}), nm, 13'd0};
            else
                half_to_single = s | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] x);
        logic [15:0] sg;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] m;
        logic [4:0]  sh;
        logic [23:0] hq;
        logic [23:0] rem;
        logic [23:0] hf;
        logic [15:0] h;
        begin
            sg  = {x[31], 15'd0};
            ex  = x[30:23];
            man = x[22:0];
            m   = {1'b1, man};
            sh  = 5'(9'd126 - {1'b0, ex});
            hq  = m >> sh;
            rem = m & ((24'd1 << sh) - 24'd1);
            hf  = 24'd1 << (sh - 5'd1);
            if (ex == 8'hFF)
                single_to_half = (man != 23'd0) ? (sg | 16'h7E00 | {6'd0, man[22:13]})
                                                : (sg | 16'h7C00);
            else if (ex == 8'd0)
                single_to_half = sg;
            else if (ex >= 8'd143)
                single_to_half = sg | 16'h7C00;
            else if (ex <= 8'd112) begin
                if (ex < 8'd102)
                    single_to_half = sg;
                else begin
                    h = 16'(hq);
                    if (rem > hf || (rem == hf && h[0]))
                        h = h + 16'd1;
                    single_to_half = sg | h;
                end
            end else begin
                h = {1'b0, 5'(ex - 8'd112), man[22:13]};
                if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && h[0]))
                    h = h + 16'd1;
                single_to_half = sg | h;
            end
        end
    endfunction
endpackage

FILE: rtl/bfva_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfva_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
interface bfva_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bfva_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfva_lane
// One lane: widen, align, add, normalize, round and narrow in four stages.
// ----------------------------------------------------------------------------
module bfva_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  bfva_pkg::t_mode   i_mode,
    input  logic [15:0]       i_a,
    input  logic [15:0]       i_b,
    output logic [15:0]       o_sum
);
    import bfva_pkg::*;

    function automatic logic [31:0] flush32(input logic [31:0] x);
        flush32 = (x[30:23] == 8'd0) ? {x[31], 31'd0} : x;
    endfunction

    // ---------------- stage 1: widen, specials, align
    t_al         n_al, r_al;
    t_mode       r_m1, r_m2, r_m3;
    logic [31:0] wa, wb, fa, fb, xa, xb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [8:0]  ed;
    logic        swap;
    logic [27:0] sm_full, sm_sh;
    logic [7:0]  dsh;
    logic        sticky;

    always_comb begin
        wa = i_mode.half_mode ? half_to_single(i_a) : {i_a, 16'd0};
        wb = i_mode.half_mode ? half_to_single(i_b) : {i_b, 16'd0};
        fa = i_mode.ftz ? flush32(wa) : wa;
        fb = i_mode.ftz ? flush32(wb) : wb;
        n_al = '0;
        if (fa[30:0] > 31'h7F80_0000) begin
            n_al.special = 1'b1;
            n_al.special_val = fa | QUIET32;
        end else if (fb[30:0] > 31'h7F80_0000) begin
            n_al.special = 1'b1;
            n_al.special_val = fb | QUIET32;
        end else if (fa[30:0] == 31'h7F80_0000 && fb[30:0] == 31'h7F80_0000
                     && fa[31] != fb[31]) begin
            n_al.special = 1'b1;
            n_al.special_val = DEFAULT_NAN32;
        end else if (fa[30:0] == 31'h7F80_0000) begin
            n_al.special = 1'b1;
            n_al.special_val = fa;
        end else if (fb[30:0] == 31'h7F80_0000) begin
            n_al.special = 1'b1;
            n_al.special_val = fb;
        end
        swap = fb[30:0] > fa[30:0];
        xa = swap ? fb : fa;
        xb = swap ? fa : fb;
        ea = (xa[30:23] == 8'd0) ? 8'd1 : xa[30:23];
        eb = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
        ma = {xa[30:23] != 8'd0, xa[22:0]};
        mb = {xb[30:23] != 8'd0, xb[22:0]};
        ed = {1'b0, ea} - {1'b0, eb};
        dsh = (ed > 9'd27) ? 8'd27 : ed[7:0];
        sm_full = {1'b0, mb, 3'd0};
        sm_sh = sm_full >> dsh;
        sticky = (sm_full & ((28'd1 << dsh) - 28'd1)) != 28'd0;
        n_al.sub = xa[31] ^ xb[31];
        n_al.sign = xa[31];
        n_al.exp = ea;
        n_al.big = {1'b0, ma, 3'd0};
        n_al.small_m = sm_sh | {27'd0, sticky};
        // exact zero result of opposite signs takes +0 (round to nearest)
        if (n_al.sub && xa[30:0] == xb[30:0])
            n_al.sign = 1'b0;
    end

    // ---------------- stage 2: add
    t_sm n_sm, r_sm;
    always_comb begin
        n_sm.special = r_al.special;
        n_sm.special_val = r_al.special_val;
        n_sm.sign = r_al.sign;
        n_sm.exp = r_al.exp;
        n_sm.mag = r_al.sub ? ({1'b0, r_al.big} - {1'b0, r_al.small_m})
                            : ({1'b0, r_al.big} + {1'b0, r_al.small_m});
    end

    // ---------------- stage 3: normalize, round
    logic [31:0] n_res, r_res;
    logic [4:0]  lz;
    logic [28:0] nm;
    logic [9:0]  ne;
    logic [28:0] sh_m;
    logic [4:0]  lsh;
    logic [24:0] rm;
    logic [9:0]  fe;
    logic        g, st;

    always_comb begin
        lz = 5'd28;
        for (int i = 0; i <= 28; i++)
            if (r_sm.mag[i]) lz = 5'(28 - i);
        ne = 10'd0;
        nm = r_sm.mag;
        lsh = 5'd0;
        sh_m = '0;
        rm = '0;
        fe = '0;
        g = 1'b0;
        st = 1'b0;
        if (r_sm.special)
            n_res = r_sm.special_val;
        else if (r_sm.mag == 29'd0)
            n_res = {r_sm.sign, 31'd0};
        else begin
            // leading one belongs at bit 26; a carry lands it at bit 27
            if (r_sm.mag[27]) begin
                nm = {1'b0, r_sm.mag[28:2], r_sm.mag[1] | r_sm.mag[0]};
                ne = {2'd0, r_sm.exp} + 10'd1;
            end else begin
                // shift left by lz-2, bounded so exponent stays >= 1
                lsh = (({5'd0, lz} - 10'd2) >= {2'd0, r_sm.exp}) ?
                      5'(r_sm.exp - 8'd1) : 5'(lz - 5'd2);
                nm = r_sm.mag << lsh;
                ne = {2'd0, r_sm.exp} - {5'd0, lsh};
            end
            sh_m = nm;
            g  = sh_m[2];
            st = sh_m[1] | sh_m[0];
            rm = {1'b0, sh_m[26:3]};
            if (g && (st || rm[0]))
                rm = rm + 25'd1;
            fe = ne;
            if (rm[24]) begin
                rm = rm >> 1;
                fe = fe + 10'd1;
            end
            if (!rm[23])
                fe = 10'd0;
            if (fe >= 10'd255)
                n_res = {r_sm.sign, 8'hFF, 23'd0};
            else
                n_res = {r_sm.sign, fe[7:0], rm[22:0]};
        end
        if (r_m2.ftz && !r_sm.special)
            n_res = flush32(n_res);
    end

    // ---------------- stage 4: narrow
    logic [15:0] n_out, r_out;
    logic [31:0] bsum;
    always_comb begin
        bsum = r_res + BF_ROUND;
        n_out = r_m3.half_mode ? single_to_half(r_res) : bsum[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_al  <= n_al;
            r_m1  <= i_mode;
            r_sm  <= n_sm;
            r_m2  <= r_m1;
            r_res <= n_res;
            r_m3  <= r_m2;
            r_out <= n_out;
        end
    end

    assign o_sum = r_out;
endmodule

FILE: rtl/bf16_fp16_vector_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_fp16_vector_adder
// Lane-wise adder for packed bfloat16 or IEEE half words.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless stalled and returns one word per input via
// align, add, normalize/round and narrow stages plus the output register; the
// whole pipeline advances together, so a stall on the output holds every stage.
// Configuration is captured with each word as it enters the pipeline.
module bf16_fp16_vector_adder #(
    parameter int unsigned LANES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfva_if.sink   cfg,
    bfva_if.sink   in_ch,
    bfva_if.source out_ch
);
    import bfva_pkg::*;

    localparam int unsigned NL = (LANES < MAX_LANES) ? LANES : MAX_LANES;
    localparam int unsigned DEPTH = 5;

    logic r_wire_format, r_flush;
    t_mode mode;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_last;
    logic en;
    logic [WORD_W-1:0] sums;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wire_format <= 1'b0;
            r_flush <= 1'b0;
        end else if (cfg.valid) begin
            if (cfg.data[64] == REG_WIRE_FORMAT && cfg.data[65] == 1'b0)
                r_wire_format <= cfg.data[0];
            else if (cfg.data[64] == REG_FLUSH_DENORM && cfg.data[65] == 1'b0)
                r_flush <= cfg.data[0];
        end
    end

    assign mode.half_mode = r_wire_format;
    assign mode.ftz = r_flush;

    // pipeline advances when the output slot is free or being drained
    assign en = !r_vld[DEPTH-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], in_ch.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en)
            r_last <= {r_last[DEPTH-2:0], in_ch.data[2*WORD_W]};
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LANES; gi++) begin : g_lane
            if (gi < NL) begin : g_on
                logic [15:0] s;
                bfva_lane u_lane (
                    .i_clk (i_clk),
                    .i_en  (en),
                    .i_mode(mode),
                    .i_a   (in_ch.data[gi*LANE_W +: LANE_W]),
                    .i_b   (in_ch.data[WORD_W + gi*LANE_W +: LANE_W]),
                    .o_sum (s)
                );
                assign sums[gi*LANE_W +: LANE_W] = s;
            end else begin : g_off
                assign sums[gi*LANE_W +: LANE_W] = '0;
            end
        end
    endgenerate

    // lanes register at stage 4; the output register is stage 5
    logic [WORD_W-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (en)
            r_sum <= sums;
    end

    assign out_ch.valid = r_vld[DEPTH-1];
    assign out_ch.data  = {r_last[DEPTH-1], r_sum};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |=> r_vld[0] == $past(in_ch.valid))
        else $error("request lost at pipeline entry");
endmodule
